// ===== rtl/gmf_pkg.sv =====
`default_nettype none

package gmf_pkg;

   // default line buffer depth and queue sizing
   localparam int unsigned DEF_MAX_WIDTH = 1024;
   localparam int unsigned QUEUE_DEPTH   = 8;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   // words inside the filter pipeline from accept to queue push
   localparam int unsigned PIPE_DEPTH    = 4;

   // window geometry
   localparam int unsigned WIN_SIZE = 9;
   localparam int unsigned WIN_MID  = 4;

   // register map, selected by the word address bit
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // result slots of one input word
   localparam int unsigned SLOT_LATE = 0;   // window center of the row above
   localparam int unsigned SLOT_EDGE = 1;   // last column of the row above
   localparam int unsigned SLOT_NOW  = 2;   // last-row cell passed straight out

   typedef logic [QUEUE_CNT_W-1:0] qcnt_type;
   typedef logic signed [31:0] hgt_type;
   typedef hgt_type [WIN_SIZE-1:0] win_type;

   typedef struct packed {
      hgt_type lo;
      hgt_type mid;
      hgt_type hi;
   } trio_type;

   // everything the back end needs to emit the results of one word
   typedef struct packed {
      logic [15:0] row;
      logic [9:0]  col;
      logic [2:0]  en;
      hgt_type     v0;
      hgt_type     v1;
      hgt_type     v2;
   } res_type;

   // three-input sort with parallel compares
   function automatic trio_type sort3(input hgt_type a, input hgt_type b, input hgt_type c);
      trio_type t;
      logic     ab;
      logic     ac;
      logic     bc;
      ab = a > b;
      ac = a > c;
      bc = b > c;
      t.lo  = (!ab && !ac) ? a : ((ab && !bc) ? b : c);
      t.hi  = (ab && ac) ? a : ((!ab && bc) ? b : c);
      t.mid = (ab ^ ac) ? a : ((ab ^ bc) ? c : b);
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gmf_front.sv =====
`default_nettype none

module gmf_front #(
   parameter int unsigned MAX_WIDTH = gmf_pkg::DEF_MAX_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire gmf_pkg::hgt_type req_cell_height,
   output logic                  req_stall,
   input  wire logic [10:0]      grid_width,
   input  wire logic [15:0]      grid_height,
   input  wire gmf_pkg::qcnt_type q_count,
   input  wire logic             pipe_exit,
   output logic                  s2_valid,
   output gmf_pkg::win_type      s2_win,
   output gmf_pkg::res_type      s2_meta,
   output logic                  s2_inner
);
   import gmf_pkg::*;

   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned WW = CW + 1;
   localparam int unsigned EW = (WW > 11) ? WW : 11;

   // line buffers, not cleared: fill_ff marks the written column prefix
   hgt_type older_mem [MAX_WIDTH];
   hgt_type newer_mem [MAX_WIDTH];

   logic [CW-1:0]   col_ff, col_in;
   logic [15:0]     row_ff, row_in;
   logic [WW-1:0]   fill_ff, fill_in;
   qcnt_type        inflight_ff, inflight_in;

   logic            s1_valid_ff;
   hgt_type         s1_x_ff;
   logic [CW-1:0]   s1_col_ff;
   logic [15:0]     s1_row_ff;
   logic [2:0]      s1_en_ff;
   logic            s1_inner_ff;
   logic            s1_hit_ff;
   logic            s1_known_ff;
   hgt_type         fwd_older_ff;
   hgt_type         fwd_newer_ff;
   hgt_type         rd_older_ff;
   hgt_type         rd_newer_ff;

   logic            s2_valid_ff;
   win_type         win_ff, win_in;
   res_type         meta_ff, meta_in;
   logic            inner_ff;

   logic [EW-1:0]   gw_ext;
   logic [WW-1:0]   w_eff;
   logic [15:0]     h_eff;
   logic [WW-1:0]   col_ext;
   logic            last_row;
   logic            row_end;
   logic            inner;
   logic [2:0]      en;
   logic            accept;
   logic [QUEUE_CNT_W:0] occupancy;
   hgt_type         older_val;
   hgt_type         newer_val;

   // effective grid size
   always_comb begin
      gw_ext = EW'(grid_width);
      if (grid_width == 11'd0) begin
         w_eff = WW'(1);
      end else if (gw_ext > EW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(gw_ext);
      end
      h_eff = (grid_height == 16'd0) ? 16'd1 : grid_height;
   end

   // classify the word at the current raster position
   always_comb begin
      col_ext  = {1'b0, col_ff};
      last_row = row_ff >= (h_eff - 16'd1);
      row_end  = col_ext >= (w_eff - WW'(1));
      inner    = (row_ff >= 16'd2) && ((17'(row_ff) + 17'd1) <= 17'(h_eff))
                 && (col_ext >= WW'(2)) && ((col_ext + WW'(1)) <= w_eff);
      en[SLOT_LATE] = (row_ff != 16'd0) && (col_ff != '0);
      en[SLOT_EDGE] = (row_ff != 16'd0) && row_end;
      en[SLOT_NOW]  = last_row;
   end

   // credit check against queue space
   assign occupancy = (QUEUE_CNT_W+1)'(inflight_ff) + (QUEUE_CNT_W+1)'(q_count);
   assign req_stall = occupancy >= (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // raster counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // words in flight up to the queue
   always_comb begin
      inflight_in = inflight_ff;
      if (accept && !pipe_exit) begin
         inflight_in = inflight_ff + qcnt_type'(1);
      end else if (!accept && pipe_exit) begin
         inflight_in = inflight_ff - qcnt_type'(1);
      end
   end

   // line values seen by the word in stage one
   always_comb begin
      if (s1_hit_ff) begin
         older_val = fwd_older_ff;
         newer_val = fwd_newer_ff;
      end else if (s1_known_ff) begin
         older_val = rd_older_ff;
         newer_val = rd_newer_ff;
      end else begin
         older_val = '0;
         newer_val = '0;
      end
   end

   // window shift and result description
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3 + 1] = win_ff[k*3+2];
      end
      win_in[2] = older_val;
      win_in[5] = newer_val;
      win_in[8] = s1_x_ff;
      meta_in.row = s1_row_ff;
      meta_in.col = 10'(s1_col_ff);
      meta_in.en  = s1_en_ff;
      meta_in.v0  = win_in[WIN_MID];
      meta_in.v1  = newer_val;
      meta_in.v2  = s1_x_ff;
   end

   // fill mark grows as new columns are first written
   always_comb begin
      fill_in = fill_ff;
      if (s1_valid_ff && ({1'b0, s1_col_ff} == fill_ff)) begin
         fill_in = fill_ff + WW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         fill_ff     <= '0;
         inflight_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         fill_ff     <= fill_in;
         inflight_ff <= inflight_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage one capture with bypass of the write in progress
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff      <= req_cell_height;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_en_ff     <= en;
         s1_inner_ff  <= inner;
         s1_hit_ff    <= s1_valid_ff && (s1_col_ff == col_ff);
         s1_known_ff  <= col_ext < fill_ff;
         fwd_older_ff <= newer_val;
         fwd_newer_ff <= s1_x_ff;
      end
   end

   // line buffer read
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_older_ff <= older_mem[col_ff];
         rd_newer_ff <= newer_mem[col_ff];
      end
   end

   // line buffer write: the newer row moves down into the older one
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         older_mem[s1_col_ff] <= newer_val;
         newer_mem[s1_col_ff] <= s1_x_ff;
      end
   end

   // window and stage two payload
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff   <= win_in;
         meta_ff  <= meta_in;
         inner_ff <= s1_inner_ff;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_win   = win_ff;
   assign s2_meta  = meta_ff;
   assign s2_inner = inner_ff;

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= qcnt_type'(PIPE_DEPTH))
      else $error("more words in flight than pipeline stages");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= WW'(MAX_WIDTH))
      else $error("line buffer fill mark past depth");

   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ({1'b0, s1_col_ff} <= fill_ff))
      else $error("column written beyond the filled prefix");

endmodule

`default_nettype wire

// ===== rtl/gmf_median.sv =====
`default_nettype none

module gmf_median (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire gmf_pkg::win_type in_win,
   input  wire gmf_pkg::res_type in_meta,
   input  wire logic             in_inner,
   output logic                  push,
   output gmf_pkg::res_type      push_entry,
   output logic                  pipe_exit
);
   import gmf_pkg::*;

   logic     b_valid_ff;
   trio_type row_ff [3];
   trio_type row_in [3];
   res_type  b_meta_ff;
   logic     b_inner_ff;

   logic     c_valid_ff;
   trio_type sel_ff, sel_in;
   res_type  c_meta_ff;
   logic     c_inner_ff;

   trio_type lo_t;
   trio_type mid_t;
   trio_type hi_t;
   trio_type fin_t;

   // sort each window row
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         row_in[k] = sort3(in_win[k*3], in_win[k*3+1], in_win[k*3+2]);
      end
   end

   // max of minima, median of middles, min of maxima
   always_comb begin
      lo_t  = sort3(row_ff[0].lo, row_ff[1].lo, row_ff[2].lo);
      mid_t = sort3(row_ff[0].mid, row_ff[1].mid, row_ff[2].mid);
      hi_t  = sort3(row_ff[0].hi, row_ff[1].hi, row_ff[2].hi);
      sel_in.lo  = lo_t.hi;
      sel_in.mid = mid_t.mid;
      sel_in.hi  = hi_t.lo;
   end

   // final median of three and queue entry
   always_comb begin
      fin_t      = sort3(sel_ff.lo, sel_ff.mid, sel_ff.hi);
      push_entry = c_meta_ff;
      if (c_inner_ff) begin
         push_entry.v0 = fin_t.mid;
      end
      push      = c_valid_ff && (c_meta_ff.en != 3'b000);
      pipe_exit = c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= in_valid;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         row_ff     <= row_in;
         b_meta_ff  <= in_meta;
         b_inner_ff <= in_inner;
      end
      if (b_valid_ff) begin
         sel_ff     <= sel_in;
         c_meta_ff  <= b_meta_ff;
         c_inner_ff <= b_inner_ff;
      end
   end

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> $past(b_valid_ff))
      else $error("median stage advanced without a word behind it");

endmodule

`default_nettype wire

// ===== rtl/gmf_queue.sv =====
`default_nettype none

module gmf_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire gmf_pkg::res_type push_entry,
   input  wire logic             pop,
   output gmf_pkg::res_type      head,
   output logic                  empty,
   output gmf_pkg::qcnt_type     count
);
   import gmf_pkg::*;

   res_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   qcnt_type                count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + qcnt_type'(1);
      end else if (!push && pop) begin
         count_in = count_ff - qcnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != qcnt_type'(QUEUE_DEPTH)) || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/gmf_back.sv =====
`default_nettype none

module gmf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire gmf_pkg::res_type head,
   input  wire logic             empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [15:0]           rsp_out_row,
   output logic [9:0]            rsp_out_col,
   output gmf_pkg::hgt_type      rsp_out_height,
   output logic                  rsp_last_of_run
);
   import gmf_pkg::*;

   logic [2:0]  sent_ff, sent_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] row_ff, row_in;
   logic [9:0]  col_ff, col_in;
   hgt_type     height_ff, height_in;
   logic        last_ff, last_in;

   logic [2:0]  pend;
   logic [2:0]  pick;
   logic        load;
   logic        fire;
   logic        last;

   // pick the next pending result of the head word
   always_comb begin
      pend = head.en & ~sent_ff;
      pick = 3'b000;
      if (pend[SLOT_LATE]) begin
         pick[SLOT_LATE] = 1'b1;
      end else if (pend[SLOT_EDGE]) begin
         pick[SLOT_EDGE] = 1'b1;
      end else begin
         pick[SLOT_NOW] = 1'b1;
      end
      last = (pend & ~pick) == 3'b000;
      load = !rsp_valid_ff || !rsp_stall;
      fire = load && !empty;
      pop  = fire && last;
   end

   // output word fields
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      height_in = height_ff;
      last_in   = last_ff;
      sent_in   = sent_ff;
      rsp_valid_in = load ? 1'b0 : rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         last_in      = last;
         sent_in      = last ? 3'b000 : (sent_ff | pick);
         if (pick[SLOT_LATE]) begin
            row_in    = head.row - 16'd1;
            col_in    = head.col - 10'd1;
            height_in = head.v0;
         end else if (pick[SLOT_EDGE]) begin
            row_in    = head.row - 16'd1;
            col_in    = head.col;
            height_in = head.v1;
         end else begin
            row_in    = head.row;
            col_in    = head.col;
            height_in = head.v2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sent_ff      <= 3'b000;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sent_ff      <= sent_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      height_ff <= height_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_out_height  = height_ff;
   assign rsp_last_of_run = last_ff;

   a_pending_nonzero: assert property (@(posedge clock) disable iff (reset)
      fire |-> pend != 3'b000)
      else $error("head word has no result left to send");

   a_sent_cleared: assert property (@(posedge clock) disable iff (reset)
      empty |-> sent_ff == 3'b000)
      else $error("sent mask left over with an empty queue");

endmodule

`default_nettype wire

// ===== rtl/grid_median_filter_3x3_unit.sv =====
`default_nettype none

// 3x3 median filter over a raster stream of elevation cells.
// req channel: one word per cell (req_cell_height, signed Q15.16), row by row,
// column 0 first. rsp channel: one word per filtered cell with its row and
// column; rsp_last_of_run marks the final word caused by one input word.
// Cells of rows 0..H-2 come out while the next row streams in (the median
// of the original 3x3 neighbours for inner cells, unchanged on the border);
// last-row cells come out as they arrive. An input word yields 0 to 3 words.
// Throughput: one input word per cycle while the output keeps up; output is
// one word per cycle while rsp_stall is low, so a row end that yields three
// words sends them one after another. Path: 4 filter stages to the result
// queue, then one output register.
// req_stall rises when the words in the 4-stage filter pipeline plus those
// held in the 8-entry result queue reach 8; rsp_stall holds the output word
// and backs up into that queue. Reset clears the counters, the queue and the
// fill mark of the line buffers (buffers read as zero until written), and
// sets the grid to 1024 x 1024. csr: width at 0x0, height at 0x4.
module grid_median_filter_3x3_unit #(
   parameter int unsigned MAX_WIDTH = gmf_pkg::DEF_MAX_WIDTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire gmf_pkg::hgt_type req_cell_height,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [15:0]           rsp_out_row,
   output logic [9:0]            rsp_out_col,
   output gmf_pkg::hgt_type      rsp_out_height,
   output logic                  rsp_last_of_run,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import gmf_pkg::*;

   logic [10:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        csr_write;

   logic        s2_valid;
   win_type     s2_win;
   res_type     s2_meta;
   logic        s2_inner;
   logic        push;
   res_type     push_entry;
   logic        pipe_exit;
   res_type     head;
   logic        empty;
   logic        pop;
   qcnt_type    q_count;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WIDTH:  width_in  = csr_pwdata[10:0];
            REG_HEIGHT: height_in = csr_pwdata[15:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = {21'd0, width_ff};
         REG_HEIGHT: csr_prdata = {16'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 16'd1024;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   gmf_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_cell_height (req_cell_height),
      .req_stall       (req_stall),
      .grid_width      (width_ff),
      .grid_height     (height_ff),
      .q_count         (q_count),
      .pipe_exit       (pipe_exit),
      .s2_valid        (s2_valid),
      .s2_win          (s2_win),
      .s2_meta         (s2_meta),
      .s2_inner        (s2_inner)
   );

   gmf_median u_median (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_valid),
      .in_win     (s2_win),
      .in_meta    (s2_meta),
      .in_inner   (s2_inner),
      .push       (push),
      .push_entry (push_entry),
      .pipe_exit  (pipe_exit)
   );

   gmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .count      (q_count)
   );

   gmf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_height  (rsp_out_height),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== verif/tb_grid_median_filter_3x3_unit.sv =====
`timescale 1ns / 1ps

module tb_grid_median_filter_3x3_unit;
   import gmf_pkg::*;

   localparam int MAX_W           = DEF_MAX_WIDTH;
   localparam int SETTLE_CYCLES   = 10;
   localparam int QUIET_LIMIT     = 3000;
   localparam int HOLD_OFF_CYCLES = 300;

   // one result word: row, column, height, last flag
   typedef struct packed {
      logic [15:0] row;
      logic [9:0]  col;
      hgt_type     height;
      logic        last;
   } cell_word_type;

   // directed stimulus rows
   typedef enum logic [1:0] {DIR_CELL, DIR_SET_WIDTH, DIR_SET_HEIGHT} dir_op_type;

   typedef struct packed {
      dir_op_type  op;
      logic [31:0] value;
      logic        typed;     // expected word given below, not predicted
      logic        has_out;   // typed row yields one pass-through word
      logic [15:0] e_row;
      logic [9:0]  e_col;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [31] = '{
      // default 1024 x 1024 grid: row 0 yields nothing
      '{DIR_CELL,       32'h7FFF_FFFF, 1'b1, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h8000_0000, 1'b1, 1'b0, 16'd0, 10'd0},
      // one-row grid set mid-row: cells pass straight out
      '{DIR_SET_HEIGHT, 32'd1,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h0000_0000, 1'b1, 1'b1, 16'd0, 10'd2},
      '{DIR_CELL,       32'hFFFF_FFFF, 1'b1, 1'b1, 16'd0, 10'd3},
      // width above the buffer depth clamps to it
      '{DIR_SET_WIDTH,  32'd2047,      1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h0001_0000, 1'b1, 1'b1, 16'd0, 10'd4},
      // zero width and height act as one; column past the end closes the row
      '{DIR_SET_WIDTH,  32'd0,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_SET_HEIGHT, 32'd0,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h7FFF_FFFF, 1'b1, 1'b1, 16'd0, 10'd5},
      '{DIR_CELL,       32'h8000_0000, 1'b1, 1'b1, 16'd0, 10'd0},
      // smallest grid with an inner cell
      '{DIR_SET_WIDTH,  32'd3,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_SET_HEIGHT, 32'd3,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h8000_0000, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h0000_0000, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h0001_0000, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'hFFFF_0000, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h8000_0000, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h0000_0001, 1'b0, 1'b0, 16'd0, 10'd0},
      // narrow grid: all border cells
      '{DIR_SET_WIDTH,  32'd2,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_SET_HEIGHT, 32'd2,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h0000_0005, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'hFFFF_FFFB, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h1234_5678, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'hEDCB_A987, 1'b0, 1'b0, 16'd0, 10'd0},
      // single-column grid
      '{DIR_SET_WIDTH,  32'd1,         1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'h5555_AAAA, 1'b0, 1'b0, 16'd0, 10'd0},
      '{DIR_CELL,       32'hAAAA_5555, 1'b0, 1'b0, 16'd0, 10'd0}
   };

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   hgt_type     req_cell_height = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [15:0] rsp_out_row;
   logic [9:0]  rsp_out_col;
   hgt_type     rsp_out_height;
   logic        rsp_last_of_run;
   logic        csr_psel        = 1'b0;
   logic        csr_penable     = 1'b0;
   logic        csr_pwrite      = 1'b0;
   logic [2:0]  csr_paddr       = '0;
   logic [31:0] csr_pwdata      = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // filter state mirrored for prediction
   hgt_type     line_prev2 [MAX_W];
   hgt_type     line_prev1 [MAX_W];
   hgt_type     win [9];
   int          row_cnt;
   int          col_cnt;
   logic [10:0] cfg_width  = 11'd1024;
   logic [15:0] cfg_height = 16'd1024;

   cell_word_type cells_due [$];
   int          errors        = 0;
   int          cells_sent    = 0;
   int          words_checked = 0;
   int          quiet_cycles  = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_req      = 0;
   int          hold_left     = 0;

   grid_median_filter_3x3_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cell_height (req_cell_height),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_height  (rsp_out_height),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (line_prev2[i]) begin
         line_prev2[i] = '0;
         line_prev1[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_cnt = 0;
      col_cnt = 0;
   end

   // element whose rank covers the fifth place of the window
   function automatic hgt_type window_median();
      int n_lt;
      int n_le;
      for (int i = 0; i < 9; i++) begin
         n_lt = 0;
         n_le = 0;
         for (int j = 0; j < 9; j++) begin
            if (win[j] < win[i]) n_lt++;
            if (win[j] <= win[i]) n_le++;
         end
         if (n_lt <= 4 && n_le >= 5) return win[i];
      end
      return win[4];
   endfunction

   // advance the mirrored filter by one cell, return the words it emits
   function automatic int filter_cell(input hgt_type x, output cell_word_type res [3]);
      int      w;
      int      h;
      int      r;
      int      c;
      int      n;
      int      er;
      int      ec;
      bit      last_row;
      bit      row_end;
      bit      inner;
      hgt_type v;
      w = (cfg_width == 0) ? 1 : ((int'(cfg_width) > MAX_W) ? MAX_W : int'(cfg_width));
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      r = row_cnt;
      c = (col_cnt >= MAX_W) ? MAX_W - 1 : col_cnt;
      n = 0;
      last_row = r >= h - 1;
      row_end  = c >= w - 1;
      for (int k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = line_prev2[c];
      win[5] = line_prev1[c];
      win[8] = x;
      line_prev2[c] = line_prev1[c];
      line_prev1[c] = x;
      // window center of the row above
      if (r >= 1 && c >= 1) begin
         er = r - 1;
         ec = c - 1;
         inner = er >= 1 && er + 2 <= h && ec >= 1 && ec + 2 <= w;
         v = inner ? window_median() : win[4];
         res[n] = {16'(er), 10'(ec), v, 1'b0};
         n++;
      end
      // last column of the row above
      if (r >= 1 && row_end) begin
         res[n] = {16'(r - 1), 10'(c), win[5], 1'b0};
         n++;
      end
      // last row passes straight out
      if (last_row) begin
         res[n] = {16'(r), 10'(c), x, 1'b0};
         n++;
      end
      if (n > 0) res[n-1].last = 1'b1;
      if (row_end) begin
         col_cnt = 0;
         row_cnt = last_row ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
         col_cnt = c + 1;
      end
      return n;
   endfunction

   function automatic hgt_type rand_height();
      case ($urandom_range(3))
         0: return hgt_type'(int'($urandom_range(6)) - 3);
         1: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return hgt_type'($urandom);
      endcase
   endfunction

   // offer one word and predict its results once it is taken
   task automatic send_cell(input hgt_type x, input bit typed, input bit has_out,
                            input logic [15:0] e_row, input logic [9:0] e_col);
      cell_word_type res [3];
      int            n;
      req_valid       <= 1'b1;
      req_cell_height <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
      n = filter_cell(x, res);
      if (typed) begin
         if (has_out)
            cells_due.insert(cells_due.size(), cell_word_type'({e_row, e_col, x, 1'b1}));
      end else begin
         for (int i = 0; i < n; i++) cells_due.insert(cells_due.size(), res[i]);
      end
      cells_sent++;
   endtask

   task automatic idle_gap();
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // stop sending and let the pipeline empty out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (cells_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write a register while idle, then read it back
   task automatic set_reg(input logic sel, input logic [31:0] value);
      logic [31:0] mask;
      mask = (sel == REG_WIDTH) ? 32'h0000_07FF : 32'h0000_FFFF;
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (sel == REG_WIDTH) cfg_width = value[10:0];
      else cfg_height = value[15:0];
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== (value & mask)) begin
         $display("%0t: register %0d readback expected %h got %h",
                  $time, sel, value & mask, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one random phase: random heights under one idle pattern, whole frames when h < 64
   task automatic run_phase(input int s_pct, input int r_pct, input int w, input int h,
                            input int n_items, input int hold);
      set_reg(REG_WIDTH, w);
      set_reg(REG_HEIGHT, h);
      send_idle_pct = s_pct;
      stall_pct     = r_pct;
      if (hold > 0) hold_req = hold;
      repeat (n_items) begin
         idle_gap();
         send_cell(rand_height(), 1'b0, 1'b0, '0, '0);
      end
      // close out the frame
      while (h < 64 && (row_cnt != 0 || col_cnt != 0)) begin
         idle_gap();
         send_cell(rand_height(), 1'b0, 1'b0, '0, '0);
      end
   endtask

   // output side: random stall, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // compare each taken result word with the oldest prediction
   always @(posedge clock) begin
      cell_word_type exp_w;
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cells_due.size() == 0) begin
            $display("%0t: unexpected word row %0d col %0d height %h last %b", $time,
                     rsp_out_row, rsp_out_col, rsp_out_height, rsp_last_of_run);
            errors++;
         end else begin
            exp_w = cells_due.pop_front();
            words_checked++;
            if (rsp_out_row !== exp_w.row || rsp_out_col !== exp_w.col ||
                rsp_out_height !== exp_w.height || rsp_last_of_run !== exp_w.last) begin
               $display("%0t: expected row %0d col %0d height %h last %b",
                        $time, exp_w.row, exp_w.col, exp_w.height, exp_w.last);
               $display("%0t: got      row %0d col %0d height %h last %b",
                        $time, rsp_out_row, rsp_out_col, rsp_out_height, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // watchdog on handshake activity
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles, %0d words still expected",
               $time, QUIET_LIMIT, cells_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed table
      foreach (DIR_TABLE[i]) begin
         case (DIR_TABLE[i].op)
            DIR_SET_WIDTH:  set_reg(REG_WIDTH, DIR_TABLE[i].value);
            DIR_SET_HEIGHT: set_reg(REG_HEIGHT, DIR_TABLE[i].value);
            default: send_cell(DIR_TABLE[i].value, DIR_TABLE[i].typed, DIR_TABLE[i].has_out,
                               DIR_TABLE[i].e_row, DIR_TABLE[i].e_col);
         endcase
      end
      // random frames under each idle pattern
      run_phase(0, 0, $urandom_range(3, 12), $urandom_range(3, 6), 75, HOLD_OFF_CYCLES);
      run_phase(50, 0, $urandom_range(1, 8), $urandom_range(1, 5), 75, 0);
      run_phase(0, 50, $urandom_range(3, 20), $urandom_range(2, 4), 75, 0);
      run_phase(26, 26, 3, 65535, 75, 0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d cells and %0d checked words: widths 0 to 2047, heights 0 to 65535,",
               cells_sent, words_checked);
      $display("four idle patterns and a long output hold-off that backs up the input");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/gmf_pkg.sv
rtl/gmf_front.sv
rtl/gmf_median.sv
rtl/gmf_queue.sv
rtl/gmf_back.sv
rtl/grid_median_filter_3x3_unit.sv
verif/tb_grid_median_filter_3x3_unit.sv
